// ===== rtl/glw_pkg.sv =====
// Shared types and constants for the glyph layout block.
package glw_pkg;

  // Item operation, carried on the slave tuser
  typedef enum logic [1:0] {
    OP_PLACE   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_WRAP_LIMIT = 2'd2,
    REG_SCALE_Q8   = 2'd3
  } cfg_reg_e;

  localparam int unsigned OpBits   = 2;
  localparam int unsigned RegBits  = 16;
  localparam int unsigned ScaleBits = 12;
  localparam int unsigned PointBits = 16;

  localparam logic [4:0]  HalfWidth   = 5'd8;
  localparam logic [4:0]  FullWidth   = 5'd16;
  localparam logic [4:0]  LineHeight  = 5'd16;
  localparam logic [15:0] NewlineCode = 16'h000A;

  localparam logic [15:0]          WrapLimitReset = 16'h7FFF;
  localparam logic [ScaleBits-1:0] ScaleReset     = 12'd256;

endpackage

// ===== rtl/glyph_layout_with_wrap_top.sv =====
// Glyph layout with line wrap: width store, cursor and result register.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tuser: operation; tdata: code point, width bit
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: page, source cell, width, dest, wrapped
//  cfg      | in        | cfg_we_i              | cfg_idx_i selects register, cfg_data_i value
//
// One request is taken every cycle while m_axis is not stalled. An accepted request is
// registered in the work stage along with its width store read; the wrap test and cursor
// update run from there, and a placed glyph is loaded into the result register as it leaves.
// The width store has no clear after reset; load an entry before placing it.
// Reset clears the cursors, loads the register defaults and empties both stages.
// A stalled m_axis holds the result; the work stage and the input back up behind it.
module glyph_layout_with_wrap_top #(
  parameter int CODE_BITS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] code_point, [16] width_bit, [23:17] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [7:0] glyph_page, [15:8] source_x, [23:16] source_y,
                                     // [28:24] glyph_width, [44:29] dest_x, [60:45] dest_y,
                                     // [61] wrapped, [63:62] zero

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Store address width: code points are at most 16 bits wide
  localparam int AW    = (CODE_BITS < 16) ? CODE_BITS : 16;
  localparam int Depth = 1 << AW;
  localparam int CW    = COORD_BITS;
  // Exact wrap test width: cursor times 256 plus a 16-bit advance, with headroom
  localparam int EW    = ((CW > 16) ? CW : 16) + 10;

  // Configuration registers
  logic [15:0]                     origin_x_q, origin_y_q, wrap_limit_q;
  logic [glw_pkg::ScaleBits-1:0]   scale_q8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      wrap_limit_q <= glw_pkg::WrapLimitReset;
      scale_q8_q   <= glw_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        glw_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        glw_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        glw_pkg::REG_WRAP_LIMIT: wrap_limit_q <= cfg_data_i;
        glw_pkg::REG_SCALE_Q8:   scale_q8_q   <= cfg_data_i[glw_pkg::ScaleBits-1:0];
        default: ;
      endcase
    end
  end

  // Input side
  logic          s_fire;
  logic [1:0]    in_op;
  logic [AW-1:0] in_code;
  logic          in_wbit;

  assign in_op   = s_axis_tuser[glw_pkg::OpBits-1:0];
  assign in_code = s_axis_tdata[AW-1:0];
  assign in_wbit = s_axis_tdata[glw_pkg::PointBits];
  assign s_fire  = s_axis_tvalid && s_axis_tready;

  // Width store: write loads as they are accepted, read every accepted request
  logic wbit_rd;

  glw_ram #(
    .WIDTH (1),
    .DEPTH (Depth)
  ) u_width_store (
    .clk_i   (clk_i),
    .we_i    (s_fire && (in_op == glw_pkg::OP_LOAD)),
    .waddr_i (in_code),
    .wdata_i (in_wbit),
    .re_i    (s_fire),
    .raddr_i (in_code),
    .rdata_o (wbit_rd)
  );

  // Work stage: request waiting on its width lookup
  logic          s1_valid_q, s1_valid_d;
  logic [1:0]    s1_op_q;
  logic [AW-1:0] s1_code_q;
  logic          s1_fire;

  // Result register
  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_data_q;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_op_q   <= in_op;
      s1_code_q <= in_code;
    end
  end

  // Cursors
  logic [CW-1:0] cx_q, csx_q, cy_q;
  logic [CW-1:0] cx_d, csx_d, cy_d;

  // Wrap test and advance
  logic [15:0]          code16;
  logic [4:0]           cw;
  logic [15:0]          scaled_w;
  logic signed [CW-1:0] csx_s;
  logic signed [15:0]   wrap_s, ox_s, oy_s;
  logic signed [EW-1:0] edge_v, limit_v;
  logic                 wrap_hit;
  logic [CW-1:0]        ox_c, oy_c;
  logic [CW-1:0]        cx_w, csx_w, cy_w;
  logic                 is_newline;
  logic                 result_v;
  logic [63:0]          result_data;

  always_comb begin
    code16   = 16'(s1_code_q);
    cw       = wbit_rd ? glw_pkg::FullWidth : glw_pkg::HalfWidth;
    // width is 8 or 16, so width * scale is a shift
    scaled_w = wbit_rd ? {scale_q8_q, 4'b0} : {1'b0, scale_q8_q, 3'b0};
    csx_s    = signed'(csx_q);
    wrap_s   = signed'(wrap_limit_q);
    ox_s     = signed'(origin_x_q);
    oy_s     = signed'(origin_y_q);
    ox_c     = CW'(ox_s);
    oy_c     = CW'(oy_s);

    edge_v   = (EW'(csx_s) <<< 8) + EW'(scaled_w);
    limit_v  = EW'(wrap_s) <<< 8;
    wrap_hit = edge_v > limit_v;

    // Position after an optional wrap
    cx_w  = wrap_hit ? ox_c : cx_q;
    csx_w = wrap_hit ? ox_c : csx_q;
    cy_w  = wrap_hit ? (cy_q + CW'(glw_pkg::LineHeight)) : cy_q;

    is_newline = (code16 == glw_pkg::NewlineCode);

    result_data = '0;
    result_data[7:0]   = code16[15:8];
    result_data[15:8]  = {code16[3:0], 4'b0};
    result_data[23:16] = {code16[7:4], 4'b0};
    result_data[28:24] = cw;
    result_data[44:29] = 16'(cx_w);
    result_data[60:45] = 16'(cy_w);
    result_data[61]    = wrap_hit;

    result_v = 1'b0;
    cx_d     = cx_q;
    csx_d    = csx_q;
    cy_d     = cy_q;

    if (s1_fire) begin
      case (s1_op_q)
        glw_pkg::OP_PLACE: begin
          if (is_newline) begin
            // newline: wrap once more after the width check
            cx_d  = ox_c;
            csx_d = ox_c;
            cy_d  = cy_w + CW'(glw_pkg::LineHeight);
          end else begin
            result_v = 1'b1;
            cx_d     = cx_w + CW'(cw);
            csx_d    = csx_w + CW'(scaled_w[15:8]);
            cy_d     = cy_w;
          end
        end
        glw_pkg::OP_RESTART: begin
          cx_d  = ox_c;
          csx_d = ox_c;
          cy_d  = oy_c;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      csx_q <= '0;
      cy_q  <= '0;
    end else begin
      cx_q  <= cx_d;
      csx_q <= csx_d;
      cy_q  <= cy_d;
    end
  end

  // Result register: load on a placed glyph, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = result_v;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && result_v) begin
      out_data_q <= result_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/glw_ram.sv =====
// Generic single-port-write, registered-read RAM.
module glw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
